// ===== rtl/efd_pkg.sv =====
`default_nettype none

package efd_pkg;

   localparam int VALUE_BITS        = 32;
   localparam int BYTE_BITS         = 8;
   localparam int COUNT_BITS        = 24;
   localparam int MAX_RESULTS       = 4;
   localparam int RESULT_CNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int LEN_CODE_MAX_BITS = 12;
   localparam int FIB_TERMS         = 8;
   localparam int POS_BITS          = 4;
   localparam int SUM_BITS          = 8;
   localparam int LEFT_BITS         = 5;
   localparam logic [SUM_BITS-1:0] SUM_SATURATED = '1;

   localparam int QUEUE_DEPTH     = 8;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic {
      REG_CODE_COUNT = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  error;
   } result_type;

   // results produced by one byte, slots 0..count-1 in stream order
   typedef struct packed {
      logic                       valid;
      logic [RESULT_CNT_BITS-1:0] count;
      result_type [MAX_RESULTS-1:0] slot;
   } batch_type;

   typedef struct packed {
      logic                  write;
      logic [COUNT_BITS-1:0] code_count;
   } cfg_type;

   // Zeckendorf weights 1,2,3,5,8,13,21,34
   function automatic logic [SUM_BITS-1:0] fib_weight(input logic [2:0] pos);
      logic [SUM_BITS-1:0] w;
      case (pos)
         3'd0:    w = 8'd1;
         3'd1:    w = 8'd2;
         3'd2:    w = 8'd3;
         3'd3:    w = 8'd5;
         3'd4:    w = 8'd8;
         3'd5:    w = 8'd13;
         3'd6:    w = 8'd21;
         default: w = 8'd34;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/efd_req_if.sv =====
`default_nettype none

interface efd_req_if import efd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/efd_rsp_if.sv =====
`default_nettype none

interface efd_rsp_if import efd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  last;
   logic                  error;

   modport source (output valid, output value, output last, output error, input ready);
   modport sink   (input valid, input value, input last, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/efd_csr.sv =====
`default_nettype none

module efd_csr import efd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   output      logic                     csr_pready,
   output      cfg_type                  cfg
);

   logic [COUNT_BITS-1:0] code_count_ff;
   logic [COUNT_BITS-1:0] code_count_in;
   csr_index_type         index;
   logic                  wr_strobe;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[2]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg.write      = 1'b0;
      cfg.code_count = csr_pwdata[COUNT_BITS-1:0];
      csr_prdata     = '0;
      unique case (index)
         REG_CODE_COUNT: begin
            cfg.write  = wr_strobe;
            csr_prdata = CSR_DATA_BITS'(code_count_ff);
         end
         default: begin
            cfg.write  = 1'b0;
            csr_prdata = '0;
         end
      endcase
      code_count_in = cfg.write ? cfg.code_count : code_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_count_ff <= COUNT_BITS'(1);
      end else begin
         code_count_ff <= code_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/efd_core.sv =====
`default_nettype none

module efd_core import efd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   efd_req_if.sink      req,
   input  wire cfg_type cfg,
   input  wire logic    room,
   output      batch_type batch
);

   logic                  byte_valid_ff, byte_valid_in;
   logic [BYTE_BITS-1:0]  byte_ff;
   logic                  in_mantissa_ff, in_mantissa_in;
   logic                  previous_bit_ff, previous_bit_in;
   logic [POS_BITS-1:0]   fib_position_ff, fib_position_in;
   logic [SUM_BITS-1:0]   length_sum_ff, length_sum_in;
   logic [VALUE_BITS-1:0] value_acc_ff, value_acc_in;
   logic [LEFT_BITS-1:0]  bits_left_ff, bits_left_in;
   // values still to decode: code_count minus values emitted so far
   logic [COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic                  consume;
   logic                  accept;

   assign consume   = byte_valid_ff && room;
   assign req.ready = !byte_valid_ff || room;
   assign accept    = req.valid && req.ready;
   assign byte_valid_in = accept || (byte_valid_ff && !room);

   always_comb begin : decode
      logic                       inm;
      logic                       prev;
      logic [POS_BITS-1:0]        pos;
      logic [SUM_BITS-1:0]        sum;
      logic [VALUE_BITS-1:0]      acc;
      logic [LEFT_BITS-1:0]       left;
      logic [RESULT_CNT_BITS-1:0] n;
      logic [RESULT_CNT_BITS-1:0] k;
      logic                       b;
      logic                       emit;
      logic                       err;
      logic [SUM_BITS:0]          wsum;
      logic [MAX_RESULTS:0]       rem_le;
      logic [MAX_RESULTS:0]       rem_eq;

      inm  = in_mantissa_ff;
      prev = previous_bit_ff;
      pos  = fib_position_ff;
      sum  = length_sum_ff;
      acc  = value_acc_ff;
      left = bits_left_ff;
      n    = '0;
      k    = '0;
      batch.slot = '0;

      for (int j = 0; j <= MAX_RESULTS; j++) begin
         rem_le[j] = remaining_ff <= COUNT_BITS'(j);
         rem_eq[j] = remaining_ff == COUNT_BITS'(j);
      end

      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         b    = byte_ff[i];
         emit = 1'b0;
         err  = 1'b0;
         wsum = '0;
         // once all values are out, the rest of the stream is dropped
         if (!rem_le[n]) begin
            if (inm) begin
               acc  = {acc[VALUE_BITS-2:0], b};
               left = left - LEFT_BITS'(1);
               emit = (left == '0);
            end else if (prev && b) begin
               if (sum > SUM_BITS'(VALUE_BITS) || sum == '0) begin
                  err = 1'b1;
               end else begin
                  acc  = VALUE_BITS'(1);
                  left = LEFT_BITS'(sum - SUM_BITS'(1));
                  if (left == '0) begin
                     emit = 1'b1;
                  end else begin
                     inm  = 1'b1;
                     prev = 1'b0;
                     pos  = '0;
                     sum  = '0;
                  end
               end
            end else begin
               if (b) begin
                  if (pos < POS_BITS'(FIB_TERMS)) begin
                     wsum = {1'b0, sum} + {1'b0, fib_weight(pos[2:0])};
                     sum  = wsum[SUM_BITS] ? SUM_SATURATED : wsum[SUM_BITS-1:0];
                  end else begin
                     sum = SUM_SATURATED;
                  end
               end
               prev = b;
               if (({1'b0, pos} + 5'd1) >= 5'(LEN_CODE_MAX_BITS)) begin
                  err = 1'b1;
               end else begin
                  pos = pos + POS_BITS'(1);
               end
            end

            if (emit) begin
               batch.slot[k[1:0]] = '{value: acc, last: rem_eq[n + RESULT_CNT_BITS'(1)],
                                      error: 1'b0};
               n = n + RESULT_CNT_BITS'(1);
            end else if (err) begin
               batch.slot[k[1:0]] = '{value: '0, last: 1'b0, error: 1'b1};
            end
            if (emit || err) begin
               k    = k + RESULT_CNT_BITS'(1);
               inm  = 1'b0;
               prev = 1'b0;
               pos  = '0;
               sum  = '0;
               acc  = '0;
               left = '0;
            end
         end
      end

      batch.valid     = consume;
      batch.count     = k;
      in_mantissa_in  = inm;
      previous_bit_in = prev;
      fib_position_in = pos;
      length_sum_in   = sum;
      value_acc_in    = acc;
      bits_left_in    = left;
      remaining_in    = remaining_ff - COUNT_BITS'(n);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff   <= 1'b0;
         in_mantissa_ff  <= 1'b0;
         previous_bit_ff <= 1'b0;
         fib_position_ff <= '0;
         length_sum_ff   <= '0;
         value_acc_ff    <= '0;
         bits_left_ff    <= '0;
         remaining_ff    <= COUNT_BITS'(1);
      end else begin
         byte_valid_ff <= byte_valid_in;
         if (cfg.write) begin
            in_mantissa_ff  <= 1'b0;
            previous_bit_ff <= 1'b0;
            fib_position_ff <= '0;
            length_sum_ff   <= '0;
            value_acc_ff    <= '0;
            bits_left_ff    <= '0;
            remaining_ff    <= cfg.code_count;
         end else if (consume) begin
            in_mantissa_ff  <= in_mantissa_in;
            previous_bit_ff <= previous_bit_in;
            fib_position_ff <= fib_position_in;
            length_sum_ff   <= length_sum_in;
            value_acc_ff    <= value_acc_in;
            bits_left_ff    <= bits_left_in;
            remaining_ff    <= remaining_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/efd_queue.sv =====
`default_nettype none

module efd_queue import efd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire batch_type batch,
   output      logic      room,
   efd_rsp_if.source      rsp
);

   result_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_CNT_BITS-1:0] push_cnt;
   logic                      pop;
   result_type                head;

   // a whole byte's worth of results must fit before the byte is decoded
   assign room = count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);

   assign head      = mem_ff[rd_ptr_ff];
   assign rsp.valid = (count_ff != '0);
   assign rsp.value = head.value;
   assign rsp.last  = head.last;
   assign rsp.error = head.error;

   assign pop       = rsp.valid && rsp.ready;
   assign push_cnt  = batch.valid ? QUEUE_CNT_BITS'(batch.count) : '0;
   assign count_in  = count_ff + push_cnt - QUEUE_CNT_BITS'(pop);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign wr_ptr_in = wr_ptr_ff + push_cnt[QUEUE_PTR_BITS-1:0];

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
         if (batch.valid && QUEUE_CNT_BITS'(j) < QUEUE_CNT_BITS'(batch.count)) begin
            mem_ff[wr_ptr_ff + QUEUE_PTR_BITS'(j)] <= batch.slot[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/elias_fibonacci_decoder.sv =====
// Elias-Fibonacci stream decoder.
// req carries one byte of the code stream per transaction, bit 7 decoded first.
// rsp carries one decoded result per transaction: value, last and error.
// Each byte yields zero to four results; the code_count-th value has last set,
// and after it the stream is dropped until code_count is written again.
// csr is an APB-style port with one register, code_count, at byte address 0;
// a write restarts decoding. Write it only while no transaction is pending.
// A byte accepted on req is held in the input register; once the result queue has
// room it is decoded combinationally into the queue, and its first result is then
// valid on rsp from the queue.
// Throughput: one byte per cycle while the 8-entry result queue has room for
// four more results; results leave at one per cycle, so the output side sets
// the sustained byte rate when bytes carry many codes.
// When rsp is stalled the queue fills; the held byte waits in the input
// register and req.ready drops while it waits for room. Nothing is lost.
// Reset (synchronous, active high) empties the queue, clears decode state and
// sets code_count to 1.
`default_nettype none

module elias_fibonacci_decoder import efd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   efd_req_if.sink                       req,
   efd_rsp_if.source                     rsp,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   output      logic                     csr_pready
);

   cfg_type   cfg;
   batch_type batch;
   logic      room;

   efd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   efd_core u_core (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cfg   (cfg),
      .room  (room),
      .batch (batch)
   );

   efd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .batch (batch),
      .room  (room),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire
